>>> src/pcnt_pkg.sv
// shared constants and note table of the pitch class note tracker
package pcnt_pkg;

  localparam int          NOTES             = 12;
  localparam int          HISTORY_DEPTH_DEF = 4;
  localparam logic [3:0]  NO_NOTE           = 4'd12;
  localparam logic [3:0]  LAST_NOTE         = 4'd11;

  // register indexes of the configuration port
  localparam logic [7:0]  REG_SPEED         = 8'd0;
  localparam logic [7:0]  REG_SENSITIVITY   = 8'd1;
  localparam logic [7:0]  REG_THRESHOLD     = 8'd2;
  localparam logic [7:0]  SETTING_RESET     = 8'd128;

  // frequency matching, values are Hz * 6400 (Q14.6 times 100)
  localparam logic [27:0] LOW_REF           = 28'd1674432;
  localparam logic [27:0] MATCH_TOL         = 28'd192000;

  // envelope constants, Q0.16
  localparam logic [16:0] ATTACK_FAST       = 17'd45875;
  localparam logic [16:0] ATTACK_SLOW       = 17'd26214;
  localparam logic [16:0] TARGET_DECAY      = 17'd52429;
  localparam logic [15:0] LEVEL_FLOOR       = 16'd656;
  localparam logic [15:0] FADE_BASE         = 16'd55706;

  // shared divider widths
  localparam int          DIV_NW            = 43;
  localparam int          DIV_DW            = 24;
  localparam int          DIV_QW            = 15;

  // note centers in centihertz, C4 octave
  function automatic logic [15:0] note_centihz(input logic [3:0] idx);
    logic [15:0] r;
    unique case (idx)
      4'd0:    r = 16'd26163;
      4'd1:    r = 16'd27718;
      4'd2:    r = 16'd29366;
      4'd3:    r = 16'd31113;
      4'd4:    r = 16'd32963;
      4'd5:    r = 16'd34923;
      4'd6:    r = 16'd36999;
      4'd7:    r = 16'd39200;
      4'd8:    r = 16'd41530;
      4'd9:    r = 16'd44000;
      4'd10:   r = 16'd46616;
      4'd11:   r = 16'd49388;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/pcnt_in_if.sv
// input channel: one audio frame per request
interface pcnt_in_if;
  logic        valid;
  logic        ready;
  logic        audio_valid;
  logic [15:0] volume;
  logic [19:0] peak_frequency;

  modport source (output valid, audio_valid, volume, peak_frequency, input ready);
  modport sink   (input valid, audio_valid, volume, peak_frequency, output ready);
endinterface

>>> src/pcnt_out_if.sv
// output channel: one note result per request
interface pcnt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  note_index;
  logic [15:0] level;
  logic [7:0]  stability;
  logic [7:0]  age;
  logic [3:0]  detected_note;
  logic [3:0]  dominant_note;
  logic        last_note;

  modport source (output valid, note_index, level, stability, age, detected_note,
                  dominant_note, last_note, input ready);
  modport sink   (input valid, note_index, level, stability, age, detected_note,
                  dominant_note, last_note, output ready);
endinterface

>>> src/pcnt_cfg_if.sv
// configuration write channel
interface pcnt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/pcnt_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit
module pcnt_div
  import pcnt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] numer_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              done_o,
  output logic [DIV_QW-1:0] quo_o
);

  logic [DIV_NW-1:0] rem_q;
  logic [DIV_NW-1:0] dsh_q;
  logic [DIV_QW-1:0] quo_q;
  logic [3:0]        cnt_q;
  logic              busy_q;
  logic              done_q;

  // one compare and subtract per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= numer_i;
        dsh_q  <= {{(DIV_NW-DIV_DW-DIV_QW+1){1'b0}}, den_i, {(DIV_QW-1){1'b0}}};
        quo_q  <= '0;
        cnt_q  <= 4'(DIV_QW-1);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[DIV_QW-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[DIV_QW-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
        if (cnt_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 4'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> src/pitch_class_note_tracker_core.sv
// pitch class note tracker: frame match, history vote, per-note envelopes
// Each audio frame yields 12 results, one per cycle as taken; the first waits on octave
// folding and on the 15-step target division.
// One frame in work at a time: the sequencer walks octave folding, 12 note matches,
// the history vote, at most one division for the dominant target and the envelope states
// N0, N1 and N2 per note. Reset clears all envelopes and history and sets the settings to SETTING_RESET.
module pitch_class_note_tracker_core
  import pcnt_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  pcnt_in_if.sink    in_chan,
  pcnt_out_if.source out_chan,
  pcnt_cfg_if.sink   cfg_chan
);

  localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_THR, ST_UP, ST_DN, ST_MATCH, ST_MCHK, ST_HIST, ST_VOTE, ST_NEED,
    ST_FDIV, ST_TMUL, ST_TCHK, ST_TDIV, ST_N0, ST_N1, ST_N2, ST_OUT
  } state_e;

  state_e      state_q;
  logic [7:0]  speed_q, sens_q, thr_q;
  logic [15:0] vol_q;
  logic [19:0] freq_q;
  logic [27:0] x_q, best_q;
  logic [2:0]  down_q;
  logic [3:0]  k_q, pick_q, det_q, dom_q;
  logic [SW-1:0] slot_q, j_q;
  logic [3:0]  recent_q [HISTORY_DEPTH];
  logic [CW-1:0] cnt_q [NOTES];
  logic [CW-1:0] maxc_q;
  logic [15:0] fade_q, scaled_q;
  logic [16:0] a_q;
  logic [32:0] acc_q;
  logic [40:0] prod_q;
  logic [15:0] level_q [NOTES];
  logic [15:0] target_q [NOTES];
  logic [7:0]  age_q [NOTES];
  logic [7:0]  stab_q [NOTES];

  // frame arithmetic derived from the settings
  logic [23:0] vscaled, vmin, diff, denp;
  logic [15:0] t50, dcoef, vmin_c;
  logic [11:0] sens_k;
  logic [7:0]  need;
  logic        loud;

  always_comb begin
    vscaled = {vol_q, 8'b0} - 24'(vol_q);
    t50     = 16'({thr_q, 5'b0}) + 16'({thr_q, 4'b0}) + 16'({thr_q, 1'b0});
    vmin_c  = 16'd2550 + t50;
    vmin    = {2'b0, vmin_c[13:0], 8'b0};
    diff    = vscaled - vmin;
    loud    = (vscaled >= vmin);
    dcoef   = 16'd62475 - t50;
    denp    = 24'({dcoef, 8'b0}) - 24'(dcoef);
    sens_k  = 12'd765 + 12'({sens_q, 3'b0}) - 12'(sens_q);
    need    = (sens_q >= 8'd110) ? 8'd1 : (sens_q >= 8'd37) ? 8'd2 : 8'd3;
  end

  // fade step (16384*speed + 127) / 255 as 64*speed + (64*speed + 127) / 255
  logic [15:0] fade_y, fade_quo;
  always_comb begin
    fade_y   = {2'b0, speed_q, 6'b0} + 16'd127;
    fade_quo = {2'b0, speed_q, 6'b0} + ((fade_y + 16'd1 + (fade_y >> 8)) >> 8);
  end

  // note match distance for the current candidate
  logic [27:0] ref_sh, ndist, tol_sh, top_sh;
  always_comb begin
    ref_sh = {6'b0, note_centihz(k_q), 6'b0} << down_q;
    ndist  = (x_q > ref_sh) ? x_q - ref_sh : ref_sh - x_q;
    tol_sh = MATCH_TOL << down_q;
    top_sh = (LOW_REF << 1) << down_q;
  end

  // history vote count for the current slot
  logic [3:0]    vote_n;
  logic [CW-1:0] vote_c;
  always_comb begin
    vote_n = recent_q[j_q];
    vote_c = (vote_n < NO_NOTE) ? cnt_q[vote_n] + CW'(1) : '0;
  end

  // envelope values of the current note
  logic        is_dom;
  logic [7:0]  age_inc, stab_inc;
  logic [16:0] a_new, tsum;
  logic [15:0] tgt_dom, lv_fade;
  logic [32:0] nl_sum;
  always_comb begin
    is_dom   = (k_q == dom_q);
    age_inc  = (age_q[k_q] < 8'd255) ? age_q[k_q] + 8'd1 : age_q[k_q];
    stab_inc = (stab_q[k_q] > 8'd253) ? 8'd255 : stab_q[k_q] + 8'd2;
    a_new    = (age_inc < 8'd3) ? ATTACK_FAST : ATTACK_SLOW;
    tsum     = 17'd32768 + 17'(scaled_q);
    tgt_dom  = tsum[16] ? 16'hFFFF : tsum[15:0];
    nl_sum   = acc_q + prod_q[32:0] + 33'd32768;
    lv_fade  = prod_q[31:16];
  end

  // shared multiplier operand select, product registered
  logic [23:0] mul_a;
  logic [16:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_TMUL: begin
        mul_a = diff;
        mul_b = 17'(sens_k);
      end
      ST_N0: begin
        mul_a = is_dom ? 24'(level_q[k_q]) : 24'(target_q[k_q]);
        mul_b = is_dom ? 17'd65536 - a_new : TARGET_DECAY;
      end
      ST_N1: begin
        mul_a = is_dom ? 24'(target_q[k_q]) : 24'(level_q[k_q]);
        mul_b = is_dom ? a_q : 17'(fade_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 41'(mul_a) * 41'(mul_b);
  end

  // shared divider: dominant note target
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_numer;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_QW-1:0] div_quo;
  logic              clamp;

  always_comb begin
    clamp     = (prod_q[35:0] >= {4'b0, denp, 8'b0});
    div_start = (state_q == ST_TCHK) && !clamp;
    div_numer = {prod_q[35:0], 7'b0};
    div_den   = denp;
  end

  pcnt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (div_numer),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // handshakes
  assign in_chan.ready  = (state_q == ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid         = (state_q == ST_OUT);
  assign out_chan.note_index    = k_q;
  assign out_chan.level         = level_q[k_q];
  assign out_chan.stability     = stab_q[k_q];
  assign out_chan.age           = age_q[k_q];
  assign out_chan.detected_note = det_q;
  assign out_chan.dominant_note = dom_q;
  assign out_chan.last_note     = (k_q == LAST_NOTE);

  // sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      speed_q  <= SETTING_RESET;
      sens_q   <= SETTING_RESET;
      thr_q    <= SETTING_RESET;
      slot_q   <= '0;
      j_q      <= '0;
      k_q      <= '0;
      det_q    <= NO_NOTE;
      dom_q    <= NO_NOTE;
      maxc_q   <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) recent_q[i] <= NO_NOTE;
      for (int i = 0; i < NOTES; i++) begin
        level_q[i]  <= '0;
        target_q[i] <= '0;
        age_q[i]    <= '0;
        stab_q[i]   <= '0;
        cnt_q[i]    <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_chan.valid) begin
        unique case (cfg_chan.index)
          REG_SPEED:       speed_q <= cfg_chan.data;
          REG_SENSITIVITY: sens_q  <= cfg_chan.data;
          REG_THRESHOLD:   thr_q   <= cfg_chan.data;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_chan.valid && in_chan.audio_valid) begin
            vol_q   <= in_chan.volume;
            freq_q  <= in_chan.peak_frequency;
            state_q <= ST_THR;
          end
        end
        ST_THR: begin
          det_q <= NO_NOTE;
          if (loud && freq_q != 20'd0) begin
            x_q     <= 28'(freq_q) * 28'd100;
            state_q <= ST_UP;
          end else begin
            state_q <= ST_HIST;
          end
        end
        // fold up into the reference octave
        ST_UP: begin
          if (x_q < LOW_REF) begin
            x_q <= x_q << 1;
          end else begin
            down_q  <= '0;
            state_q <= ST_DN;
          end
        end
        // count octaves above it
        ST_DN: begin
          if (x_q >= top_sh) begin
            down_q <= down_q + 3'd1;
          end else begin
            k_q     <= '0;
            best_q  <= '1;
            state_q <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          if (ndist < best_q) begin
            best_q <= ndist;
            pick_q <= k_q;
          end
          if (k_q == LAST_NOTE) state_q <= ST_MCHK;
          else k_q <= k_q + 4'd1;
        end
        ST_MCHK: begin
          det_q   <= (best_q > tol_sh) ? NO_NOTE : pick_q;
          state_q <= ST_HIST;
        end
        ST_HIST: begin
          recent_q[slot_q] <= det_q;
          slot_q  <= (slot_q == SW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + SW'(1);
          for (int i = 0; i < NOTES; i++) cnt_q[i] <= '0;
          maxc_q  <= '0;
          dom_q   <= NO_NOTE;
          j_q     <= '0;
          state_q <= ST_VOTE;
        end
        ST_VOTE: begin
          if (vote_n < NO_NOTE) begin
            cnt_q[vote_n] <= vote_c;
            if (vote_c > maxc_q) begin
              maxc_q <= vote_c;
              dom_q  <= vote_n;
            end
          end
          if (j_q == SW'(HISTORY_DEPTH - 1)) state_q <= ST_NEED;
          else j_q <= j_q + SW'(1);
        end
        ST_NEED: begin
          if (8'(maxc_q) < need) dom_q <= NO_NOTE;
          state_q <= ST_FDIV;
        end
        ST_FDIV: begin
          fade_q <= FADE_BASE - fade_quo;
          if (dom_q != NO_NOTE && vscaled > vmin) begin
            state_q <= ST_TMUL;
          end else begin
            scaled_q <= '0;
            k_q      <= '0;
            state_q  <= ST_N0;
          end
        end
        ST_TMUL: state_q <= ST_TCHK;
        ST_TCHK: begin
          if (clamp) begin
            scaled_q <= 16'd32768;
            k_q      <= '0;
            state_q  <= ST_N0;
          end else begin
            state_q  <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (div_done) begin
            scaled_q <= 16'(div_quo);
            k_q      <= '0;
            state_q  <= ST_N0;
          end
        end
        // per-note envelope in states N0, N1 and N2
        ST_N0: begin
          if (is_dom) begin
            age_q[k_q]    <= age_inc;
            stab_q[k_q]   <= stab_inc;
            target_q[k_q] <= tgt_dom;
            a_q           <= a_new;
          end
          state_q <= ST_N1;
        end
        ST_N1: begin
          if (is_dom) acc_q <= prod_q[32:0];
          else target_q[k_q] <= prod_q[31:16];
          state_q <= ST_N2;
        end
        ST_N2: begin
          if (is_dom) begin
            level_q[k_q] <= nl_sum[31:16];
          end else begin
            level_q[k_q] <= (lv_fade < LEVEL_FLOOR) ? 16'd0 : lv_fade;
            if (age_q[k_q] != 8'd0) age_q[k_q] <= age_q[k_q] - 8'd1;
            if (stab_q[k_q] != 8'd0) stab_q[k_q] <= stab_q[k_q] - 8'd1;
          end
          if (k_q == LAST_NOTE) begin
            k_q     <= '0;
            state_q <= ST_OUT;
          end else begin
            k_q     <= k_q + 4'd1;
            state_q <= ST_N0;
          end
        end
        ST_OUT: begin
          if (out_chan.ready) begin
            if (k_q == LAST_NOTE) state_q <= ST_IDLE;
            else k_q <= k_q + 4'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> test/testbench.sv
// testbench of the pitch class note tracker: directed frames, random phases, envelope predictor
module testbench;
  import pcnt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST = 4;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [3:0]  note_index;
    logic [15:0] level;
    logic [7:0]  stability;
    logic [7:0]  age;
    logic [3:0]  detected_note;
    logic [3:0]  dominant_note;
    logic        last_note;
  } note_result_t;

  typedef struct {
    bit          audio_valid;
    logic [15:0] volume;
    logic [19:0] freq;
    logic [3:0]  want_det;  // 15: taken from the envelope predictor
  } frame_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pcnt_in_if  in_if();
  pcnt_out_if out_if();
  pcnt_cfg_if cfg_if();

  pitch_class_note_tracker_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #2 clk_i = ~clk_i;

  // envelope state mirror
  logic [15:0] env_level [NOTES];
  logic [15:0] env_target[NOTES];
  logic [7:0]  env_age   [NOTES];
  logic [7:0]  env_stab  [NOTES];
  logic [3:0]  vote_hist [HIST];
  int          vote_slot;
  logic [7:0]  speed_set, sens_set, thresh_set;

  note_result_t pending_notes[$];
  int           fail_count = 0;
  int           results_seen = 0;

  // fold the frequency into the C4 octave and pick the nearest note
  function automatic logic [3:0] fold_match(logic [19:0] f);
    longint unsigned x, low, refv, d, best;
    int down;
    logic [3:0] pick;
    x = longint'(f) * 100;
    low = longint'(LOW_REF);
    down = 0;
    best = '1;
    pick = NO_NOTE;
    if (f == 0) return NO_NOTE;
    while (x < low) x = x << 1;
    while (x >= ((2 * low) << down)) down++;
    for (int i = 0; i < NOTES; i++) begin
      refv = (longint'(note_centihz(4'(i))) * 64) << down;
      d = (x > refv) ? x - refv : refv - x;
      if (d < best) begin
        best = d;
        pick = 4'(i);
      end
    end
    if (best > (longint'(MATCH_TOL) << down)) return NO_NOTE;
    return pick;
  endfunction

  // advance the envelopes by one frame and queue the twelve note results
  function automatic void track_frame(logic [15:0] vol, logic [19:0] fq, logic [3:0] want_det);
    longint vscaled, vmin, num;
    longint unsigned scaled, den, tgt, a, nl, fade;
    int counts[NOTES];
    int maxc, need;
    logic [3:0] det, dom, n;
    note_result_t r;
    vscaled = longint'(vol) * 255;
    vmin = 256 * (2550 + 50 * longint'(thresh_set));
    fade = 55706 - (16384 * longint'(speed_set) + 127) / 255;
    det = (vscaled >= vmin) ? fold_match(fq) : NO_NOTE;
    if (want_det != 4'd15 && want_det != det) begin
      $error("detected_note table: expected %0d, actual %0d", want_det, det);
      fail_count++;
    end
    vote_hist[vote_slot] = det;
    vote_slot = (vote_slot + 1) % HIST;
    dom = NO_NOTE;
    maxc = 0;
    foreach (counts[i]) counts[i] = 0;
    for (int i = 0; i < HIST; i++) begin
      n = vote_hist[i];
      if (n < NOTES) begin
        counts[n]++;
        if (counts[n] > maxc) begin
          maxc = counts[n];
          dom = n;
        end
      end
    end
    need = (sens_set >= 110) ? 1 : (sens_set >= 37) ? 2 : 3;
    if (maxc < need) dom = NO_NOTE;
    for (int i = 0; i < NOTES; i++) begin
      if (i == dom) begin
        num = (vscaled - vmin) * (765 + 7 * longint'(sens_set));
        scaled = 0;
        if (num > 0) begin
          den = 256 * (62475 - 50 * longint'(thresh_set)) * 255;
          scaled = (longint'(num) * 32768) / den;
          if (scaled > 32768) scaled = 32768;
        end
        tgt = 32768 + scaled;
        if (tgt > 65535) tgt = 65535;
        env_target[i] = 16'(tgt);
        if (env_age[i] < 255) env_age[i]++;
        env_stab[i] = (env_stab[i] > 253) ? 8'd255 : env_stab[i] + 8'd2;
        a = (env_age[i] < 3) ? ATTACK_FAST : ATTACK_SLOW;
        nl = (longint'(env_level[i]) * (65536 - a) + tgt * a + 32768) >> 16;
        env_level[i] = 16'(nl);
      end else begin
        env_target[i] = 16'((longint'(env_target[i]) * TARGET_DECAY) >> 16);
        env_level[i] = 16'((longint'(env_level[i]) * fade) >> 16);
        if (env_age[i] > 0) env_age[i]--;
        if (env_stab[i] > 0) env_stab[i]--;
        if (env_level[i] < LEVEL_FLOOR) env_level[i] = '0;
      end
    end
    for (int i = 0; i < NOTES; i++) begin
      r.note_index = 4'(i);
      r.level = env_level[i];
      r.stability = env_stab[i];
      r.age = env_age[i];
      r.detected_note = det;
      r.dominant_note = dom;
      r.last_note = (4'(i) == LAST_NOTE);
      pending_notes.push_back(r);
    end
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // offer one frame request and mirror it once taken
  task automatic send_frame(bit av, logic [15:0] vol, logic [19:0] fq, logic [3:0] want_det);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.audio_valid <= av;
    in_if.volume <= vol;
    in_if.peak_frequency <= fq;
    do @(posedge clk_i); while (!in_if.ready);
    if (av) track_frame(vol, fq, want_det);
  endtask

  // wait until every result is in and the block has settled
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_notes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register write request, valid kept high for the next
  task automatic cfg_write(logic [7:0] idx, logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_SPEED:       speed_set = val;
      REG_SENSITIVITY: sens_set = val;
      REG_THRESHOLD:   thresh_set = val;
      default: ;
    endcase
  endtask

  task automatic program_settings(logic [7:0] s, logic [7:0] se, logic [7:0] t);
    cfg_write(8'd3 + 8'($urandom_range(252)), 8'($urandom));
    cfg_write(REG_SPEED, s);
    cfg_write(REG_SENSITIVITY, se);
    cfg_write(REG_THRESHOLD, t);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker with random stalls and one long hold-off
  initial begin
    int off_cnt;
    bit held;
    note_result_t got, want;
    off_cnt = 0;
    held = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.note_index = out_if.note_index;
        got.level = out_if.level;
        got.stability = out_if.stability;
        got.age = out_if.age;
        got.detected_note = out_if.detected_note;
        got.dominant_note = out_if.dominant_note;
        got.last_note = out_if.last_note;
        results_seen++;
        if (pending_notes.size() == 0) begin
          $error("note result with no request pending: note_index %0d", got.note_index);
          fail_count++;
        end else begin
          want = pending_notes.pop_front();
          if (got.note_index != want.note_index) begin
            $error("note_index: expected %0d, actual %0d", want.note_index, got.note_index);
            fail_count++;
          end
          if (got.level != want.level) begin
            $error("level: expected %0d, actual %0d", want.level, got.level);
            fail_count++;
          end
          if (got.stability != want.stability) begin
            $error("stability: expected %0d, actual %0d", want.stability, got.stability);
            fail_count++;
          end
          if (got.age != want.age) begin
            $error("age: expected %0d, actual %0d", want.age, got.age);
            fail_count++;
          end
          if (got.detected_note != want.detected_note) begin
            $error("detected_note: expected %0d, actual %0d",
                   want.detected_note, got.detected_note);
            fail_count++;
          end
          if (got.dominant_note != want.dominant_note) begin
            $error("dominant_note: expected %0d, actual %0d",
                   want.dominant_note, got.dominant_note);
            fail_count++;
          end
          if (got.last_note != want.last_note) begin
            $error("last_note: expected %0d, actual %0d", want.last_note, got.last_note);
            fail_count++;
          end
        end
      end
      if (!held && results_seen >= 600) begin
        held = 1'b1;
        off_cnt = 1500;
      end
      if (off_cnt > 0) begin
        off_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(99) < 25) off_cnt = pick_gap();
      end
    end
  end

  // timeout
  initial begin
    #30_000_000;
    $display("pitch_class_note_tracker_core test failed");
    $finish;
  end

  // stimulus
  initial begin
    frame_row_t rows[$];
    logic [7:0] phase_cfg[6][3];
    logic [3:0] tune;
    logic [15:0] vol;
    logic [19:0] fq;
    longint unsigned base;
    int k, p, run_len;

    in_if.valid = 1'b0;
    in_if.audio_valid = 1'b0;
    in_if.volume = '0;
    in_if.peak_frequency = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    speed_set = SETTING_RESET;
    sens_set = SETTING_RESET;
    thresh_set = SETTING_RESET;
    foreach (env_level[i]) begin
      env_level[i] = '0;
      env_target[i] = '0;
      env_age[i] = '0;
      env_stab[i] = '0;
    end
    foreach (vote_hist[i]) vote_hist[i] = NO_NOTE;
    vote_slot = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed frames under reset settings
    rows.push_back('{1'b1, 16'hFFFF, 20'd28160, 4'd9});    // a4 exactly
    rows.push_back('{1'b1, 16'hFFFF, 20'd28160, 4'd9});
    rows.push_back('{1'b1, 16'hFFFF, 20'd56320, 4'd9});    // one octave up
    rows.push_back('{1'b1, 16'h0000, 20'd28160, NO_NOTE}); // silent
    rows.push_back('{1'b1, 16'd8985, 20'd28160, NO_NOTE}); // just under threshold
    rows.push_back('{1'b1, 16'd8986, 20'd28160, 4'd9});    // at threshold
    rows.push_back('{1'b1, 16'hFFFF, 20'd0, NO_NOTE});     // zero frequency
    rows.push_back('{1'b0, 16'hFFFF, 20'd28160, 4'd15});   // no audio
    rows.push_back('{1'b1, 16'hFFFF, 20'd1, 4'd15});
    rows.push_back('{1'b1, 16'hFFFF, 20'hFFFFF, 4'd15});
    rows.push_back('{1'b1, 16'hFFFF, 20'd16744, 4'd11});   // just below c4 folds to b
    for (int i = 0; i < NOTES; i++)
      rows.push_back('{1'b1, 16'hC000, 20'((note_centihz(4'(i)) * 64) / 100), 4'd15});
    foreach (rows[i])
      send_frame(rows[i].audio_valid, rows[i].volume, rows[i].freq, rows[i].want_det);
    drain();

    // random phases over several settings
    phase_cfg = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255},
                  '{8'd128, 8'd36, 8'd60}, '{8'd60, 8'd37, 8'd200},
                  '{8'd200, 8'd109, 8'd10}, '{8'd17, 8'd110, 8'd128}};
    for (int ph = 0; ph < 6; ph++) begin
      program_settings(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2]);
      tune = 4'($urandom_range(11));
      run_len = 0;
      for (int it = 0; it < 66; it++) begin
        if (run_len == 0) begin
          tune = 4'($urandom_range(11));
          run_len = $urandom_range(8, 2);
        end
        run_len--;
        p = $urandom_range(99);
        if (p < 70) begin
          // held note with jitter in some octave
          base = longint'(note_centihz(tune)) * 64;
          k = $urandom_range(7) - 3;
          base = (k >= 0) ? base << k : base >> (-k);
          fq = 20'(base / 100 + $urandom_range(6) - 3);
          vol = 16'($urandom_range(65535, 4000));
          send_frame(1'b1, vol, fq, 4'd15);
        end else if (p < 82) begin
          send_frame(1'b1, 16'($urandom_range(9000)), 20'($urandom), 4'd15);
        end else if (p < 95) begin
          send_frame(1'b1, 16'($urandom), 20'($urandom), 4'd15);
        end else begin
          send_frame(1'b0, 16'($urandom), 20'($urandom), 4'd15);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("pitch_class_note_tracker_core test passed");
    end else begin
      $display("pitch_class_note_tracker_core test failed");
    end
    $finish;
  end

endmodule
